// File: src/motor_mit_command_packer_top_defines.svh
// Assertion macros shared by the command packer RTL.
`ifndef MOTOR_MIT_COMMAND_PACKER_TOP_DEFINES_SVH
`define MOTOR_MIT_COMMAND_PACKER_TOP_DEFINES_SVH

// Implication checked on the same edge.
`define MCP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("command packer check failed");

// Implication checked a fixed number of cycles later.
`define MCP_ASSERT_DELAY(label, clk, rst_n, a, n, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##n (b)) \
    else $error("command packer latency check failed");

`endif

// File: src/mcp_pkg.sv
// Shared constants and types of the MIT command packer.
package mcp_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned NumW   = 49;
  localparam int unsigned DenW   = 33;
  localparam int unsigned IdW    = 11;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned NLanes = 5;
  localparam int unsigned PosBits = 16;
  localparam int unsigned StdBits = 12;

  localparam logic signed [ValW-1:0] KpLow  = 32'sd0;
  localparam logic signed [ValW-1:0] KpHigh = 32'sd32768000;
  localparam logic signed [ValW-1:0] KdLow  = 32'sd0;
  localparam logic signed [ValW-1:0] KdHigh = 32'sd327680;

  typedef enum logic [IdxW-1:0] {
    RegPosLow  = 3'd0,
    RegPosHigh = 3'd1,
    RegVelLow  = 3'd2,
    RegVelHigh = 3'd3,
    RegTrqLow  = 3'd4,
    RegTrqHigh = 3'd5,
    RegMotorId = 3'd6,
    RegNone    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

endpackage

// File: src/mcp_prep.sv
// Clamp, offset and numerator/divisor preparation for one value.
module mcp_prep #(
  parameter int unsigned CodeBits = mcp_pkg::PosBits
) (
  input  logic                              clk_i,
  input  logic signed [mcp_pkg::ValW-1:0]   value_i,
  input  logic signed [mcp_pkg::ValW-1:0]   lo_i,
  input  logic signed [mcp_pkg::ValW-1:0]   hi_i,
  output logic        [mcp_pkg::NumW-1:0]   num_o,
  output logic        [mcp_pkg::DenW-1:0]   den_o,
  output logic                              err_o
);

  logic signed [mcp_pkg::ValW-1:0] clamp;
  logic signed [mcp_pkg::ValW:0]   off_wide, span_wide;
  logic [mcp_pkg::ValW-1:0] off_d, off_q, span_d, span_q;
  logic err_d, err_q;
  logic [mcp_pkg::NumW-1:0] scaled, num_d, num_q;
  logic [mcp_pkg::DenW-1:0] den_d, den_q;
  logic err2_q;

  always_comb begin
    err_d = (lo_i >= hi_i);
    if (value_i < lo_i) begin
      clamp = lo_i;
    end else if (value_i > hi_i) begin
      clamp = hi_i;
    end else begin
      clamp = value_i;
    end
    off_wide  = (mcp_pkg::ValW+1)'(clamp) - (mcp_pkg::ValW+1)'(lo_i);
    span_wide = (mcp_pkg::ValW+1)'(hi_i) - (mcp_pkg::ValW+1)'(lo_i);
    off_d  = off_wide[mcp_pkg::ValW-1:0];
    span_d = span_wide[mcp_pkg::ValW-1:0];
  end

  // off * (2^bits - 1) is a shift and a subtract.
  always_comb begin
    scaled = (mcp_pkg::NumW'(off_q) << CodeBits) - mcp_pkg::NumW'(off_q);
    num_d  = (scaled << 1) + mcp_pkg::NumW'(span_q);
    den_d  = {span_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    span_q <= span_d;
    err_q  <= err_d;
    num_q  <= num_d;
    den_q  <= den_d;
    err2_q <= err_q;
  end

  assign num_o = num_q;
  assign den_o = den_q;
  assign err_o = err2_q;

endmodule

// File: src/mcp_div_cell.sv
// One restoring-division cell: resolves one quotient bit and passes on.
module mcp_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                        clk_i,
  input  logic [mcp_pkg::DenW-1:0]    rem_i,
  input  logic [mcp_pkg::QuoW-1:0]    low_i,
  input  logic [mcp_pkg::DenW-1:0]    den_i,
  input  logic [mcp_pkg::QuoW-1:0]    quo_i,
  output logic [mcp_pkg::DenW-1:0]    rem_o,
  output logic [mcp_pkg::QuoW-1:0]    low_o,
  output logic [mcp_pkg::DenW-1:0]    den_o,
  output logic [mcp_pkg::QuoW-1:0]    quo_o
);

  logic [mcp_pkg::DenW:0]   trial;
  logic [mcp_pkg::DenW-1:0] rem_d, rem_q, den_q;
  logic [mcp_pkg::QuoW-1:0] quo_d, quo_q, low_q;

  always_comb begin
    trial = {rem_i, low_i[BitIdx]};
    quo_d = quo_i;
    if (trial >= (mcp_pkg::DenW+1)'(den_i)) begin
      rem_d = mcp_pkg::DenW'(trial - (mcp_pkg::DenW+1)'(den_i));
      quo_d[BitIdx] = 1'b1;
    end else begin
      rem_d = trial[mcp_pkg::DenW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    low_q <= low_i;
    den_q <= den_i;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign low_o = low_q;
  assign den_o = den_q;

endmodule

// File: src/motor_mit_command_packer_top.sv
// Top level of the MIT-mode motor command packer.
//
// A command transaction is taken at a rising edge with start_i high and
// busy_o low; busy_o is never raised, so one command can enter every cycle.
// The five Q16.16 values are clamped to their ranges and scaled to 16-bit
// (position) or 12-bit codes with round-half-up, then packed into the eight
// payload bytes. frame_id_o carries the configured motor id.
// Each value runs through two preparation stages and a chain of 16
// restoring-division cells, one quotient bit per cell, plus an output
// register that drives result_valid_o, which holds for one cycle.
// Throughput is one command per cycle. If any range has its low limit not
// below its high limit, range_error_o is set and all payload bytes are zero.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i; the
// user must do so only while no command is in flight, which the block does
// not enforce. Reset loads the default limits and motor id and clears every
// in-flight command. The receiver cannot stall the block.
`include "motor_mit_command_packer_top_defines.svh"

module motor_mit_command_packer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cfg_we_i,
  input  logic [mcp_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [mcp_pkg::ValW-1:0]          cfg_wdata_i,
  input  logic signed [mcp_pkg::ValW-1:0]   target_position_i,
  input  logic signed [mcp_pkg::ValW-1:0]   target_velocity_i,
  input  logic signed [mcp_pkg::ValW-1:0]   stiffness_gain_i,
  input  logic signed [mcp_pkg::ValW-1:0]   damping_gain_i,
  input  logic signed [mcp_pkg::ValW-1:0]   feedforward_torque_i,
  output logic                              result_valid_o,
  output logic [mcp_pkg::IdW-1:0]           frame_id_o,
  output logic [7:0]                        payload_byte0_o,
  output logic [7:0]                        payload_byte1_o,
  output logic [7:0]                        payload_byte2_o,
  output logic [7:0]                        payload_byte3_o,
  output logic [7:0]                        payload_byte4_o,
  output logic [7:0]                        payload_byte5_o,
  output logic [7:0]                        payload_byte6_o,
  output logic [7:0]                        payload_byte7_o,
  output logic                              range_error_o
);

  localparam int unsigned NCells  = mcp_pkg::QuoW;
  localparam int unsigned NStages = NCells + 2;
  localparam int unsigned Latency = NStages + 1;

  logic signed [mcp_pkg::ValW-1:0] pos_lo_q, pos_hi_q, vel_lo_q, vel_hi_q;
  logic signed [mcp_pkg::ValW-1:0] trq_lo_q, trq_hi_q;
  logic [mcp_pkg::IdW-1:0] motor_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lo_q   <= -32'sd819200;
      pos_hi_q   <= 32'sd819200;
      vel_lo_q   <= -32'sd1966080;
      vel_hi_q   <= 32'sd1966080;
      trq_lo_q   <= -32'sd655360;
      trq_hi_q   <= 32'sd655360;
      motor_id_q <= 11'd1;
    end else if (cfg_we_i) begin
      case (mcp_pkg::reg_idx_e'(cfg_index_i))
        mcp_pkg::RegPosLow:  pos_lo_q   <= cfg_wdata_i;
        mcp_pkg::RegPosHigh: pos_hi_q   <= cfg_wdata_i;
        mcp_pkg::RegVelLow:  vel_lo_q   <= cfg_wdata_i;
        mcp_pkg::RegVelHigh: vel_hi_q   <= cfg_wdata_i;
        mcp_pkg::RegTrqLow:  trq_lo_q   <= cfg_wdata_i;
        mcp_pkg::RegTrqHigh: trq_hi_q   <= cfg_wdata_i;
        mcp_pkg::RegMotorId: motor_id_q <= cfg_wdata_i[mcp_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic signed [mcp_pkg::ValW-1:0] lane_val [mcp_pkg::NLanes];
  logic signed [mcp_pkg::ValW-1:0] lane_lo  [mcp_pkg::NLanes];
  logic signed [mcp_pkg::ValW-1:0] lane_hi  [mcp_pkg::NLanes];
  logic [mcp_pkg::NumW-1:0] lane_num [mcp_pkg::NLanes];
  logic [mcp_pkg::DenW-1:0] lane_den [mcp_pkg::NLanes];
  logic [mcp_pkg::NLanes-1:0] lane_err;

  logic [mcp_pkg::DenW-1:0] rem_w [mcp_pkg::NLanes][NCells+1];
  logic [mcp_pkg::QuoW-1:0] low_w [mcp_pkg::NLanes][NCells+1];
  logic [mcp_pkg::DenW-1:0] den_w [mcp_pkg::NLanes][NCells+1];
  logic [mcp_pkg::QuoW-1:0] quo_w [mcp_pkg::NLanes][NCells+1];

  assign lane_val[0] = target_position_i;
  assign lane_val[1] = target_velocity_i;
  assign lane_val[2] = stiffness_gain_i;
  assign lane_val[3] = damping_gain_i;
  assign lane_val[4] = feedforward_torque_i;
  assign lane_lo[0] = pos_lo_q;
  assign lane_hi[0] = pos_hi_q;
  assign lane_lo[1] = vel_lo_q;
  assign lane_hi[1] = vel_hi_q;
  assign lane_lo[2] = mcp_pkg::KpLow;
  assign lane_hi[2] = mcp_pkg::KpHigh;
  assign lane_lo[3] = mcp_pkg::KdLow;
  assign lane_hi[3] = mcp_pkg::KdHigh;
  assign lane_lo[4] = trq_lo_q;
  assign lane_hi[4] = trq_hi_q;

  for (genvar l = 0; l < mcp_pkg::NLanes; l++) begin : g_lane
    mcp_prep #(
      .CodeBits((l == 0) ? mcp_pkg::PosBits : mcp_pkg::StdBits)
    ) u_prep (
      .clk_i   (clk_i),
      .value_i (lane_val[l]),
      .lo_i    (lane_lo[l]),
      .hi_i    (lane_hi[l]),
      .num_o   (lane_num[l]),
      .den_o   (lane_den[l]),
      .err_o   (lane_err[l])
    );

    // The quotient fits in 16 bits, so the high numerator bits already
    // form a partial remainder below the divisor.
    assign rem_w[l][0] = lane_num[l][mcp_pkg::NumW-1:mcp_pkg::QuoW];
    assign low_w[l][0] = lane_num[l][mcp_pkg::QuoW-1:0];
    assign den_w[l][0] = lane_den[l];
    assign quo_w[l][0] = '0;

    for (genvar c = 0; c < NCells; c++) begin : g_cell
      mcp_div_cell #(
        .BitIdx(NCells - 1 - c)
      ) u_cell (
        .clk_i (clk_i),
        .rem_i (rem_w[l][c]),
        .low_i (low_w[l][c]),
        .den_i (den_w[l][c]),
        .quo_i (quo_w[l][c]),
        .rem_o (rem_w[l][c+1]),
        .low_o (low_w[l][c+1]),
        .den_o (den_w[l][c+1]),
        .quo_o (quo_w[l][c+1])
      );
    end
  end

  // Control travels beside the data: stages 0 and 1 are the preparation
  // registers, the rest follow the division cells.
  mcp_pkg::ctl_t ctl_q [NStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStages; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0].valid <= start_i && !busy_o;
      ctl_q[0].err   <= 1'b0;
      ctl_q[1].valid <= ctl_q[0].valid;
      ctl_q[1].err   <= 1'b0;
      ctl_q[2].valid <= ctl_q[1].valid;
      ctl_q[2].err   <= |lane_err;
      for (int i = 3; i < NStages; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  logic [mcp_pkg::QuoW-1:0] code [mcp_pkg::NLanes];

  always_comb begin
    for (int l = 0; l < mcp_pkg::NLanes; l++) begin
      code[l] = quo_w[l][NCells];
      if (l != 0 && code[l] > mcp_pkg::QuoW'((1 << mcp_pkg::StdBits) - 1)) begin
        code[l] = mcp_pkg::QuoW'((1 << mcp_pkg::StdBits) - 1);
      end
    end
  end

  logic valid_q, err_q;
  logic [7:0] byte_q [8];
  logic [7:0] byte_d [8];

  always_comb begin
    byte_d[0] = code[0][15:8];
    byte_d[1] = code[0][7:0];
    byte_d[2] = code[1][11:4];
    byte_d[3] = {code[1][3:0], code[2][11:8]};
    byte_d[4] = code[2][7:0];
    byte_d[5] = code[3][11:4];
    byte_d[6] = {code[3][3:0], code[4][11:8]};
    byte_d[7] = code[4][7:0];
    if (ctl_q[NStages-1].err) begin
      for (int b = 0; b < 8; b++) begin
        byte_d[b] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_q[NStages-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= ctl_q[NStages-1].err;
    for (int b = 0; b < 8; b++) begin
      byte_q[b] <= byte_d[b];
    end
  end

  assign result_valid_o  = valid_q;
  assign range_error_o   = err_q;
  assign frame_id_o      = motor_id_q;
  assign payload_byte0_o = byte_q[0];
  assign payload_byte1_o = byte_q[1];
  assign payload_byte2_o = byte_q[2];
  assign payload_byte3_o = byte_q[3];
  assign payload_byte4_o = byte_q[4];
  assign payload_byte5_o = byte_q[5];
  assign payload_byte6_o = byte_q[6];
  assign payload_byte7_o = byte_q[7];

  `MCP_ASSERT_DELAY(a_latency, clk_i, rst_ni, start_i && !busy_o, 19, result_valid_o)
  `MCP_ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, result_valid_o && range_error_o, (payload_byte0_o | payload_byte1_o | payload_byte2_o | payload_byte3_o | payload_byte4_o | payload_byte5_o | payload_byte6_o | payload_byte7_o) == 8'd0)
  `MCP_ASSERT_IMPLY(a_pos_code, clk_i, rst_ni, ctl_q[NStages-1].valid && !ctl_q[NStages-1].err, quo_w[0][NCells] <= mcp_pkg::QuoW'((1 << mcp_pkg::PosBits) - 1) && Latency == 19)

endmodule
